/* hdl/ct97_pkg.sv */
// Shared constants, payload types and pipeline metadata for the 9x7 census core.
package ct97_pkg;

  // Pixel and geometry constants
  localparam int PIX_W      = 8;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int PAD_COLS   = 4;
  localparam int PAD_ROWS   = 3;
  localparam int LINE_LEN   = MAX_WIDTH + PAD_COLS;
  localparam int ADDR_W     = $clog2(LINE_LEN);
  localparam int WIN_ROWS   = 7;
  localparam int WIN_COLS   = 9;
  localparam int STORE_ROWS = WIN_ROWS - 1;
  localparam int CENSUS_W   = WIN_ROWS * WIN_COLS;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 13;
  localparam int CX_W       = 10;
  localparam int CY_W       = 12;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [COL_W-1:0] WIDTH_RESET  = COL_W'(640);
  localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(480);

  // Input item kinds
  localparam logic MODE_PIXEL   = 1'b0;
  localparam logic MODE_PADDING = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [WIN_ROWS-1:0][PIX_W-1:0] col_t;
  typedef logic [STORE_ROWS-1:0][PIX_W-1:0] store_word_t;

  typedef struct packed {
    logic mode;
    pix_t pixel;
  } in_beat_t;

  typedef struct packed {
    logic [CENSUS_W-1:0] census;
    logic [CX_W-1:0]     center_x;
    logic [CY_W-1:0]     center_y;
    logic                last;
    logic                mode_error;
  } out_beat_t;

  // Per-item bookkeeping that rides along with the pixel data
  typedef struct packed {
    logic                has_centre;
    logic                err;
    logic                last;
    logic [CX_W-1:0]     cx;
    logic [CY_W-1:0]     cy;
    logic [WIN_COLS-1:0] col_ok;
    logic [WIN_ROWS-1:0] row_ok;
  } meta_t;

endpackage

/* hdl/ct97_line_mem.sv */
// Line store memory: one word per column holding the six previous rows.
module ct97_line_mem (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [ct97_pkg::ADDR_W-1:0] waddr_i,
  input  ct97_pkg::store_word_t       wdata_i,
  input  logic                       re_i,
  input  logic [ct97_pkg::ADDR_W-1:0] raddr_i,
  output ct97_pkg::store_word_t       rdata_o
);

  ct97_pkg::store_word_t mem_q [ct97_pkg::LINE_LEN];
  ct97_pkg::store_word_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/ct97_win_cell.sv */
// One window column cell: seven pixels, shifted left from its neighbor each beat.
module ct97_win_cell (
  input  logic                       clk_i,
  input  logic                       shift_i,
  input  ct97_pkg::col_t              col_i,
  input  ct97_pkg::pix_t              centre_i,
  output ct97_pkg::col_t              col_o,
  output logic [ct97_pkg::WIN_ROWS-1:0] le_o
);

  ct97_pkg::col_t col_q;

  // Column register, takes the neighbor's column on a shift
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  // Compare each held pixel against the window center
  always_comb begin
    for (int r = 0; r < ct97_pkg::WIN_ROWS; r++) begin
      le_o[r] = (col_q[r] <= centre_i);
    end
  end

  assign col_o = col_q;

endmodule

/* hdl/census_transform_9x7_core.sv */
// Top level of the streaming 9x7 census transform core.
//
// Pixels enter on the in_* channel in raster order over a grid of
// (image_width+4) columns by (image_height+3) rows; positions right of or
// below the image are sent with mode set to padding. A beat is taken when
// in_valid_i is high and in_stall_o is low. For each beat the census of the
// pixel 4 columns left and 3 rows up leaves on the out_* channel, if that
// pixel lies in the image; a beat whose mode disagrees with its position
// also gives a result, with mode_error set.
// Throughput is one beat per cycle while out_stall_i is low; a beat passes
// the line memory read, the window shift and the census register in turn
// before out_valid_o rises. A stall on out_stall_i holds the output
// register; the two stages behind it keep filling, so up to two more beats
// that give a result are taken before in_stall_o rises. Beats that give no
// result keep passing through. Configuration writes (cfg_*) are always
// ready, and a width or height write returns the position to the start of
// the frame; issue them only while the core is idle.
// Reset sets width 640, height 480 and the frame position to zero. The line
// memory needs no clearing: rows above the image are masked by position.
module census_transform_9x7_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ct97_pkg::in_beat_t             in_beat_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ct97_pkg::out_beat_t            out_beat_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ct97_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ct97_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration and frame position
  logic [ct97_pkg::COL_W-1:0] width_q;
  logic [ct97_pkg::ROW_W-1:0] height_q;
  logic [ct97_pkg::COL_W-1:0] w_eff, col_q, col_d, col_p1;
  logic [ct97_pkg::ROW_W-1:0] h_eff, row_q, row_d, row_p1;
  logic                       cfg_wr, cfg_hit;

  // Pipeline control
  logic in_acc, s1_go, s1_free, s2_go, s2_free, out_free, s2_emit;
  logic s1_valid_q, s2_valid_q, out_valid_q;

  // Payload stages
  ct97_pkg::pix_t                 s1_pix_q;
  logic [ct97_pkg::ADDR_W-1:0]    s1_addr_q;
  ct97_pkg::meta_t                acc_meta, s1_meta_q, s2_meta_q;
  ct97_pkg::out_beat_t            out_q, out_d;

  // Line memory and window
  ct97_pkg::store_word_t          mem_rdata, mem_wdata;
  ct97_pkg::col_t                 new_col;
  ct97_pkg::col_t                 cell_col [ct97_pkg::WIN_COLS];
  logic [ct97_pkg::WIN_ROWS-1:0]  cell_le  [ct97_pkg::WIN_COLS];
  ct97_pkg::pix_t                 centre;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_wr && ((cfg_index_i == ct97_pkg::CFG_IMAGE_WIDTH) ||
                                  (cfg_index_i == ct97_pkg::CFG_IMAGE_HEIGHT));

  // Register values clamped to the supported range
  always_comb begin
    if (width_q == '0) begin
      w_eff = ct97_pkg::COL_W'(1);
    end else if (width_q > ct97_pkg::COL_W'(ct97_pkg::MAX_WIDTH)) begin
      w_eff = ct97_pkg::COL_W'(ct97_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = ct97_pkg::ROW_W'(1);
    end else if (height_q > ct97_pkg::ROW_W'(ct97_pkg::MAX_HEIGHT)) begin
      h_eff = ct97_pkg::ROW_W'(ct97_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  // Handshake chain: output register, window stage, memory read stage
  assign s2_emit  = s2_meta_q.has_centre || s2_meta_q.err;
  assign out_free = !out_valid_q || !out_stall_i;
  assign s2_go    = s2_valid_q && (out_free || !s2_emit);
  assign s2_free  = !s2_valid_q || s2_go;
  assign s1_go    = s1_valid_q && s2_free;
  assign s1_free  = !s1_valid_q || s1_go;
  assign in_stall_o = !s1_free;
  assign in_acc   = in_valid_i && !in_stall_o;

  // Position advance and per-item bookkeeping at acceptance
  always_comb begin
    logic is_pad;
    logic [ct97_pkg::COL_W:0] xs;
    logic [ct97_pkg::ROW_W:0] ys;
    col_p1 = col_q + ct97_pkg::COL_W'(1);
    row_p1 = row_q + ct97_pkg::ROW_W'(1);
    col_d  = col_q;
    row_d  = row_q;
    if (col_p1 >= w_eff + ct97_pkg::COL_W'(ct97_pkg::PAD_COLS)) begin
      col_d = '0;
      if (row_p1 >= h_eff + ct97_pkg::ROW_W'(ct97_pkg::PAD_ROWS)) begin
        row_d = '0;
      end else begin
        row_d = row_p1;
      end
    end else begin
      col_d = col_p1;
    end

    is_pad = (col_q >= w_eff) || (row_q >= h_eff);
    acc_meta.err = (in_beat_i.mode == ct97_pkg::MODE_PADDING) != is_pad;
    acc_meta.has_centre = (col_q >= ct97_pkg::COL_W'(ct97_pkg::PAD_COLS)) &&
                          (row_q >= ct97_pkg::ROW_W'(ct97_pkg::PAD_ROWS));
    acc_meta.last = acc_meta.has_centre &&
                    (col_q == w_eff + ct97_pkg::COL_W'(ct97_pkg::PAD_COLS - 1)) &&
                    (row_q == h_eff + ct97_pkg::ROW_W'(ct97_pkg::PAD_ROWS - 1));
    if (acc_meta.has_centre) begin
      acc_meta.cx = ct97_pkg::CX_W'(col_q - ct97_pkg::COL_W'(ct97_pkg::PAD_COLS));
      acc_meta.cy = ct97_pkg::CY_W'(row_q - ct97_pkg::ROW_W'(ct97_pkg::PAD_ROWS));
    end else begin
      acc_meta.cx = '0;
      acc_meta.cy = '0;
    end
    // Neighbor column c sits at x-8+c, row r at y-6+r
    for (int c = 0; c < ct97_pkg::WIN_COLS; c++) begin
      xs = {1'b0, col_q} + (ct97_pkg::COL_W + 1)'(c);
      acc_meta.col_ok[c] = (xs >= (ct97_pkg::COL_W + 1)'(2 * ct97_pkg::PAD_COLS)) &&
                           (xs < {1'b0, w_eff} + (ct97_pkg::COL_W + 1)'(2 * ct97_pkg::PAD_COLS));
    end
    for (int r = 0; r < ct97_pkg::WIN_ROWS; r++) begin
      ys = {1'b0, row_q} + (ct97_pkg::ROW_W + 1)'(r);
      acc_meta.row_ok[r] = (ys >= (ct97_pkg::ROW_W + 1)'(2 * ct97_pkg::PAD_ROWS)) &&
                           (ys < {1'b0, h_eff} + (ct97_pkg::ROW_W + 1)'(2 * ct97_pkg::PAD_ROWS));
    end
  end

  // Config registers and frame position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ct97_pkg::WIDTH_RESET;
      height_q <= ct97_pkg::HEIGHT_RESET;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      if (cfg_wr && (cfg_index_i == ct97_pkg::CFG_IMAGE_WIDTH)) begin
        width_q <= cfg_data_i[ct97_pkg::COL_W-1:0];
      end
      if (cfg_wr && (cfg_index_i == ct97_pkg::CFG_IMAGE_HEIGHT)) begin
        height_q <= cfg_data_i[ct97_pkg::ROW_W-1:0];
      end
      if (cfg_hit) begin
        col_q <= '0;
        row_q <= '0;
      end else if (in_acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_acc;
      end
      if (s2_free) begin
        s2_valid_q <= s1_go;
      end
      if (out_free) begin
        out_valid_q <= s2_go && s2_emit;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q  <= in_beat_i.pixel;
      s1_addr_q <= col_q[ct97_pkg::ADDR_W-1:0];
      s1_meta_q <= acc_meta;
    end
    if (s1_go) begin
      s2_meta_q <= s1_meta_q;
    end
    if (out_free && s2_go && s2_emit) begin
      out_q <= out_d;
    end
  end

  // Line memory: read at acceptance, written back one row up with the new pixel
  always_comb begin
    for (int r = 0; r < ct97_pkg::STORE_ROWS; r++) begin
      new_col[r] = mem_rdata[r];
    end
    new_col[ct97_pkg::WIN_ROWS-1] = s1_pix_q;
    for (int r = 0; r < ct97_pkg::STORE_ROWS; r++) begin
      mem_wdata[r] = new_col[r + 1];
    end
  end

  ct97_line_mem u_line_mem (
    .clk_i   (clk_i),
    .we_i    (s1_go),
    .waddr_i (s1_addr_q),
    .wdata_i (mem_wdata),
    .re_i    (in_acc),
    .raddr_i (col_q[ct97_pkg::ADDR_W-1:0]),
    .rdata_o (mem_rdata)
  );

  // Window: a chain of column cells, the newest column enters at the right
  assign centre = cell_col[ct97_pkg::WIN_COLS / 2][ct97_pkg::WIN_ROWS / 2];

  for (genvar c = 0; c < ct97_pkg::WIN_COLS; c++) begin : g_cell
    if (c == ct97_pkg::WIN_COLS - 1) begin : g_head
      ct97_win_cell u_cell (
        .clk_i    (clk_i),
        .shift_i  (s1_go),
        .col_i    (new_col),
        .centre_i (centre),
        .col_o    (cell_col[c]),
        .le_o     (cell_le[c])
      );
    end else begin : g_body
      ct97_win_cell u_cell (
        .clk_i    (clk_i),
        .shift_i  (s1_go),
        .col_i    (cell_col[c + 1]),
        .centre_i (centre),
        .col_o    (cell_col[c]),
        .le_o     (cell_le[c])
      );
    end
  end

  // Census word, masked by position; top-left neighbor lands in the MSB
  always_comb begin
    out_d.census = '0;
    for (int r = 0; r < ct97_pkg::WIN_ROWS; r++) begin
      for (int c = 0; c < ct97_pkg::WIN_COLS; c++) begin
        out_d.census[ct97_pkg::CENSUS_W - 1 - (r * ct97_pkg::WIN_COLS + c)] =
          s2_meta_q.has_centre && s2_meta_q.row_ok[r] && s2_meta_q.col_ok[c] &&
          cell_le[c][r];
      end
    end
    out_d.center_x   = s2_meta_q.cx;
    out_d.center_y   = s2_meta_q.cy;
    out_d.last       = s2_meta_q.last;
    out_d.mode_error = s2_meta_q.err;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

`ifndef SYNTH
  // Frame position stays inside the padded grid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q < w_eff + ct97_pkg::COL_W'(ct97_pkg::PAD_COLS)) &&
    (row_q < h_eff + ct97_pkg::ROW_W'(ct97_pkg::PAD_ROWS)))
    else $error("frame position left the padded grid");

  // Line memory never reads the column it writes back in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && in_acc) |-> (s1_addr_q != col_q[ct97_pkg::ADDR_W-1:0]))
    else $error("line memory read and write collide");

  // The final census of a frame always carries its own center bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last) |->
      out_q.census[ct97_pkg::CENSUS_W / 2])
    else $error("last census without centre bit");
`endif

endmodule
